/* rtl/core/asl_pkg.sv */
// Shared types, token codes and the mnemonic table for the assembly source lexer.
package asl_pkg;

    localparam logic [3:0] KIND_EOF      = 4'd0;
    localparam logic [3:0] KIND_NEWLINE  = 4'd1;
    localparam logic [3:0] KIND_COMMA    = 4'd2;
    localparam logic [3:0] KIND_LPAREN   = 4'd3;
    localparam logic [3:0] KIND_RPAREN   = 4'd4;
    localparam logic [3:0] KIND_COLON    = 4'd5;
    localparam logic [3:0] KIND_MNEMONIC = 4'd6;
    localparam logic [3:0] KIND_XREG     = 4'd7;
    localparam logic [3:0] KIND_FREG     = 4'd8;
    localparam logic [3:0] KIND_IMM      = 4'd9;
    localparam logic [3:0] KIND_IDENT    = 4'd10;
    localparam logic [3:0] KIND_STRING   = 4'd11;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_F      = 8'h66;

    localparam logic [31:0] IMM_CAP = 32'h8000_0000;

    localparam int NUM_MNEMONICS = 42;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_COMMENT,
        MODE_STRING
    } lex_mode_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [5:0]  mnemonic;
        logic [4:0]  reg_idx;
        logic [31:0] imm;
        logic [63:0] text;
        logic [3:0]  len;
        logic        trunc;
        logic        last;
    } token_t;

    // Literals hold the first character in the highest used byte.
    localparam logic [47:0] MN_TEXT [NUM_MNEMONICS] = '{
        48'("nop"), 48'("hlt"),
        48'("add"), 48'("sub"), 48'("sll"), 48'("slt"), 48'("sltu"), 48'("xor"),
        48'("srl"), 48'("sra"), 48'("or"), 48'("and"),
        48'("addi"), 48'("slli"), 48'("slti"), 48'("sltiu"), 48'("xori"),
        48'("srli"), 48'("srai"), 48'("ori"), 48'("andi"),
        48'("lb"), 48'("lh"), 48'("lw"), 48'("lbu"), 48'("lhu"),
        48'("sb"), 48'("sh"), 48'("sw"),
        48'("beq"), 48'("bne"), 48'("blt"), 48'("bge"), 48'("bltu"), 48'("bgeu"),
        48'("lui"), 48'("auipc"), 48'("jal"), 48'("jalr"),
        48'("flw"), 48'("fsw"), 48'("fadd.s")
    };

    localparam logic [3:0] MN_LEN [NUM_MNEMONICS] = '{
        4'd3, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd3, 4'd3, 4'd3, 4'd2, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd3, 4'd4,
        4'd2, 4'd2, 4'd2, 4'd3, 4'd3,
        4'd2, 4'd2, 4'd2,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd3, 4'd5, 4'd3, 4'd4,
        4'd3, 4'd3, 4'd6
    };

    // Reorder a mnemonic so its first character sits in the lowest byte.
    function automatic logic [63:0] mn_bytes(input int m);
        logic [63:0] res;
        int          l;
        res = '0;
        l   = int'(MN_LEN[m]);
        for (int k = 0; k < 6; k++)
        begin
            if (k < l)
            begin
                res[8*k +: 8] = MN_TEXT[m][8*(l-1-k) +: 8];
            end
        end
        return res;
    endfunction

endpackage

/* rtl/core/assembly_source_lexer.sv */
// Top level of the assembly source lexer: input register, tokenizer and result queue.
// Throughput: one byte per cycle while the result side takes one token per cycle;
//   a byte makes up to two tokens, and the four-entry result queue sets the pace
//   when the consumer falls behind.
// Reset: rst_n clears mode, word and string buffers, and empties both the input
//   register and the result queue at once; no clearing pass.
module assembly_source_lexer #(
    parameter int MAX_TEXT_LEN = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [5:0]  mnemonic_code,
    output logic [4:0]  reg_index,
    output logic signed [31:0] imm_value,
    output logic [63:0] token_text,
    output logic [3:0]  text_len,
    output logic        text_truncated,
    output logic        last
);

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  len;
        logic        ovf;
    } text_t;

    // Append one byte unless the buffer holds MAX_TEXT_LEN bytes (and never more than eight); flag overflow then.
    function automatic text_t text_append(input text_t t, input logic [7:0] c);
        text_t r;
        r = t;
        if (t.len < 4'(MAX_TEXT_LEN) && t.len < 4'd8)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (t.len[2:0] == 3'(k))
                begin
                    r.bytes[8*k +: 8] = c;
                end
            end
            r.len = t.len + 4'd1;
        end
        else
        begin
            r.ovf = 1'b1;
        end
        return r;
    endfunction

    // Input register stage
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       eoi_reg;
    logic       fire;

    // Lexer state
    asl_pkg::lex_mode_t mode_reg, mode_next;
    text_t       word_reg, word_next;
    text_t       str_reg, str_next;
    logic        num_ok_reg, num_ok_next;
    logic        num_neg_reg, num_neg_next;
    logic        num_digit_reg, num_digit_next;
    logic [31:0] num_mag_reg, num_mag_next;

    // Result queue
    asl_pkg::token_t fifo_reg [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;
    logic        pop;

    asl_pkg::token_t tok0, tok1, word_tok, str_tok, sym_tok;
    logic [1:0]  n_tok;

    // Word classification
    logic        mn_hit;
    logic [5:0]  mn_code;
    logic [7:0]  b0, b1, b2;
    logic        b1_digit, b2_digit;
    logic [6:0]  reg_val;
    logic        reg_ok;
    logic [31:0] imm_val;
    logic [3:0]  sym_kind;
    logic [35:0] mag_prod;

    assign fire     = in_valid_reg && (count_reg <= 3'd2);
    assign in_stall = in_valid_reg && !fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            char_reg <= char_in;
            eoi_reg  <= end_of_input;
        end
    end

    always_comb
    begin
        mn_hit  = 1'b0;
        mn_code = '0;
        for (int m = 0; m < asl_pkg::NUM_MNEMONICS; m++)
        begin
            if (!mn_hit && word_reg.len == asl_pkg::MN_LEN[m]
                && word_reg.bytes == asl_pkg::mn_bytes(m))
            begin
                mn_hit  = 1'b1;
                mn_code = 6'(m);
            end
        end
    end

    assign b0 = word_reg.bytes[7:0];
    assign b1 = word_reg.bytes[15:8];
    assign b2 = word_reg.bytes[23:16];
    assign b1_digit = (b1 >= asl_pkg::CH_ZERO) && (b1 <= asl_pkg::CH_NINE);
    assign b2_digit = (b2 >= asl_pkg::CH_ZERO) && (b2 <= asl_pkg::CH_NINE);

    always_comb
    begin
        reg_val = 7'(b1 - asl_pkg::CH_ZERO);
        reg_ok  = (b0 == asl_pkg::CH_X || b0 == asl_pkg::CH_F) && b1_digit
                  && (word_reg.len == 4'd2 || word_reg.len == 4'd3);
        if (word_reg.len == 4'd3)
        begin
            reg_val = 7'(b1 - asl_pkg::CH_ZERO) * 7'd10 + 7'(b2 - asl_pkg::CH_ZERO);
            if (b1 == asl_pkg::CH_ZERO || !b2_digit || reg_val > 7'd31)
            begin
                reg_ok = 1'b0;
            end
        end
    end

    // Negative values wrap through two's complement; positive ones clamp below the cap.
    assign imm_val = num_neg_reg ? (32'd0 - num_mag_reg)
                   : ((num_mag_reg >= asl_pkg::IMM_CAP) ? asl_pkg::IMM_CAP - 32'd1
                                                         : num_mag_reg);

    always_comb
    begin
        word_tok = '0;
        if (!word_reg.ovf && mn_hit)
        begin
            word_tok.kind     = asl_pkg::KIND_MNEMONIC;
            word_tok.mnemonic = mn_code;
        end
        else if (!word_reg.ovf && reg_ok)
        begin
            word_tok.kind    = (b0 == asl_pkg::CH_X) ? asl_pkg::KIND_XREG : asl_pkg::KIND_FREG;
            word_tok.reg_idx = reg_val[4:0];
        end
        else if (num_ok_reg && num_digit_reg)
        begin
            word_tok.kind = asl_pkg::KIND_IMM;
            word_tok.imm  = imm_val;
        end
        else
        begin
            word_tok.kind  = asl_pkg::KIND_IDENT;
            word_tok.text  = word_reg.bytes;
            word_tok.len   = word_reg.len;
            word_tok.trunc = word_reg.ovf;
        end
    end

    always_comb
    begin
        str_tok       = '0;
        str_tok.kind  = asl_pkg::KIND_STRING;
        str_tok.text  = str_reg.bytes;
        str_tok.len   = str_reg.len;
        str_tok.trunc = str_reg.ovf;
    end

    always_comb
    begin
        case (char_reg)
            asl_pkg::CH_NL:     sym_kind = asl_pkg::KIND_NEWLINE;
            asl_pkg::CH_COMMA:  sym_kind = asl_pkg::KIND_COMMA;
            asl_pkg::CH_LPAREN: sym_kind = asl_pkg::KIND_LPAREN;
            asl_pkg::CH_RPAREN: sym_kind = asl_pkg::KIND_RPAREN;
            asl_pkg::CH_COLON:  sym_kind = asl_pkg::KIND_COLON;
            default:            sym_kind = asl_pkg::KIND_EOF;
        endcase
        sym_tok      = '0;
        sym_tok.kind = sym_kind;
    end

    assign mag_prod = {4'd0, num_mag_reg} * 36'd10 + 36'(char_reg - asl_pkg::CH_ZERO);

    // Next state and the tokens for the byte in the input register
    always_comb
    begin
        mode_next      = mode_reg;
        word_next      = word_reg;
        str_next       = str_reg;
        num_ok_next    = num_ok_reg;
        num_neg_next   = num_neg_reg;
        num_digit_next = num_digit_reg;
        num_mag_next   = num_mag_reg;
        tok0  = '0;
        tok1  = '0;
        n_tok = 2'd0;
        if (fire)
        begin
            if (eoi_reg)
            begin
                // End of source: flush an open string, then eof, then back to reset.
                if (mode_reg == asl_pkg::MODE_STRING)
                begin
                    tok0  = str_tok;
                    n_tok = 2'd2;
                end
                else
                begin
                    tok0  = '0;
                    n_tok = 2'd1;
                end
                tok1           = '0;
                mode_next      = asl_pkg::MODE_NORMAL;
                word_next      = '0;
                str_next       = '0;
                num_ok_next    = 1'b1;
                num_neg_next   = 1'b0;
                num_digit_next = 1'b0;
                num_mag_next   = '0;
            end
            else
            begin
                case (mode_reg)
                    asl_pkg::MODE_COMMENT:
                    begin
                        if (char_reg == asl_pkg::CH_NL)
                        begin
                            mode_next = asl_pkg::MODE_NORMAL;
                        end
                    end
                    asl_pkg::MODE_STRING:
                    begin
                        if (char_reg == asl_pkg::CH_QUOTE)
                        begin
                            tok0      = str_tok;
                            n_tok     = 2'd1;
                            str_next  = '0;
                            mode_next = asl_pkg::MODE_NORMAL;
                        end
                        else
                        begin
                            str_next = text_append(str_reg, char_reg);
                        end
                    end
                    default:
                    begin
                        if (char_reg == asl_pkg::CH_SEMI)
                        begin
                            mode_next = asl_pkg::MODE_COMMENT;
                        end
                        else if (char_reg == asl_pkg::CH_QUOTE)
                        begin
                            str_next  = '0;
                            mode_next = asl_pkg::MODE_STRING;
                        end
                        else if (char_reg == asl_pkg::CH_SPACE
                                 || sym_kind != asl_pkg::KIND_EOF)
                        begin
                            if (word_reg.len != 4'd0)
                            begin
                                tok0           = word_tok;
                                tok1           = sym_tok;
                                n_tok          = (sym_kind != asl_pkg::KIND_EOF) ? 2'd2 : 2'd1;
                                word_next      = '0;
                                num_ok_next    = 1'b1;
                                num_neg_next   = 1'b0;
                                num_digit_next = 1'b0;
                                num_mag_next   = '0;
                            end
                            else if (sym_kind != asl_pkg::KIND_EOF)
                            begin
                                tok0  = sym_tok;
                                n_tok = 2'd1;
                            end
                        end
                        else
                        begin
                            if (char_reg >= asl_pkg::CH_ZERO && char_reg <= asl_pkg::CH_NINE)
                            begin
                                num_digit_next = 1'b1;
                                num_mag_next   = (mag_prod > 36'(asl_pkg::IMM_CAP))
                                               ? asl_pkg::IMM_CAP : mag_prod[31:0];
                            end
                            else if (char_reg == asl_pkg::CH_MINUS && word_reg.len == 4'd0)
                            begin
                                num_neg_next = 1'b1;
                            end
                            else
                            begin
                                num_ok_next = 1'b0;
                            end
                            word_next = text_append(word_reg, char_reg);
                        end
                    end
                endcase
            end
        end
        tok0.last = (n_tok == 2'd1);
        tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= asl_pkg::MODE_NORMAL;
            word_reg      <= '0;
            str_reg       <= '0;
            num_ok_reg    <= 1'b1;
            num_neg_reg   <= 1'b0;
            num_digit_reg <= 1'b0;
            num_mag_reg   <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            word_reg      <= word_next;
            str_reg       <= str_next;
            num_ok_reg    <= num_ok_next;
            num_neg_reg   <= num_neg_next;
            num_digit_reg <= num_digit_next;
            num_mag_reg   <= num_mag_next;
        end
    end

    // Result queue: push up to two tokens, pop one per beat.
    assign pop = (count_reg != 3'd0) && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_tok;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            count_reg  <= count_reg + 3'(n_tok) - 3'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_tok != 2'd0)
        begin
            fifo_reg[wr_ptr_reg] <= tok0;
        end
        if (n_tok == 2'd2)
        begin
            fifo_reg[wr_ptr_reg + 2'd1] <= tok1;
        end
    end

    assign out_valid      = (count_reg != 3'd0);
    assign token_kind     = fifo_reg[rd_ptr_reg].kind;
    assign mnemonic_code  = fifo_reg[rd_ptr_reg].mnemonic;
    assign reg_index      = fifo_reg[rd_ptr_reg].reg_idx;
    assign imm_value      = fifo_reg[rd_ptr_reg].imm;
    assign token_text     = fifo_reg[rd_ptr_reg].text;
    assign text_len       = fifo_reg[rd_ptr_reg].len;
    assign text_truncated = fifo_reg[rd_ptr_reg].trunc;
    assign last           = fifo_reg[rd_ptr_reg].last;

endmodule

/* rtl/core/asl_checker.sv */
// Port-level checks for the assembly source lexer, bound to the top level.
module asl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  token_kind,
    input logic [5:0]  mnemonic_code,
    input logic [3:0]  text_len
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(token_kind))
        else $error("result beat dropped or changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= asl_pkg::KIND_STRING)
        else $error("token kind out of range");

    a_mn_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mnemonic_code != 6'd0 |-> token_kind == asl_pkg::KIND_MNEMONIC)
        else $error("mnemonic code on a non-mnemonic token");

    a_text_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_len != 4'd0 |->
            (token_kind == asl_pkg::KIND_IDENT || token_kind == asl_pkg::KIND_STRING)
            && text_len <= 4'd8)
        else $error("text length on a token without text");

endmodule

bind assembly_source_lexer asl_checker u_asl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .mnemonic_code (mnemonic_code),
    .text_len      (text_len)
);
